// ----- src/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- src/psts_pkg.sv -----
// Shared types and constants for the priority sleep task scheduler.
// No dependencies.
package psts_pkg;

  localparam int MAX_TASKS_DEF     = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_ACTIVATE = 3'd1,
    OP_SLEEP    = 3'd2,
    OP_WAIT     = 3'd3,
    OP_END      = 3'd4,
    OP_KILL     = 3'd5,
    OP_PICK     = 3'd6,
    OP_QUERY    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_UNREG = 3'd0,
    ST_DEAD  = 3'd1,
    ST_SLEEP = 3'd2,
    ST_WAIT  = 3'd3,
    ST_RUN   = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  task_req;
    logic [7:0]  priority_req;
    logic [31:0] delay;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    status_t    task_status;
    logic       picked_valid;
    logic [3:0] picked_task;
    logic       list_ok;
  } rsp_t;

endpackage

// ----- src/priority_sleep_task_scheduler.sv -----
// Top level of the priority sleep task scheduler.
// Depends on psts_pkg, psts_front, psts_back and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries one scheduler item: in_op,
//   in_task_req, in_priority_req, in_delay and in_now.
//   Result channel out_valid/out_ready returns exactly one result per item:
//   out_task_status, out_picked_valid, out_picked_task, out_list_ok.
//   A two-entry queue decouples acceptance from execution. The back end
//   loads one item into its command register, executes it over the
//   ordered list of cells and registers the result. It takes no new item
//   while it is executing one, nor while a held result waits to be taken.
//   Synchronous reset (rst_n low) empties the queue, marks all slots
//   unregistered, clears the list and drops the current task.
//   When the receiver stalls, the result is held and the queue keeps
//   accepting until it holds two items; then in_ready drops.
`include "assert_macros.svh"
module priority_sleep_task_scheduler #(
  parameter int MAX_TASKS     = psts_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_BITS = psts_pkg::PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_task_req,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_task_status,
  output logic        out_picked_valid,
  output logic [3:0]  out_picked_task,
  output logic        out_list_ok
);
  import psts_pkg::*;

  cmd_t in_cmd, q_cmd;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign in_cmd = '{op: op_t'(in_op), task_req: in_task_req,
                    priority_req: in_priority_req, delay: in_delay, now: in_now};

  psts_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  psts_back #(.MAX_TASKS(MAX_TASKS), .PRIORITY_BITS(PRIORITY_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp
  );

  assign out_task_status  = rsp.task_status;
  assign out_picked_valid = rsp.picked_valid;
  assign out_picked_task  = rsp.picked_task;
  assign out_list_ok      = rsp.list_ok;

  `CHK_IMPL(a_pick_status, clk, rst_n, out_valid && out_picked_valid,
            out_task_status == ST_RUN, "picked result without running status")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
            out_valid && $stable(rsp), "stalled result changed")
  `CHK_NEXT(a_no_double_take, clk, rst_n, q_valid && q_ready,
            !q_ready, "back end took two items in a row")

endmodule

// ----- src/psts_front.sv -----
// Front end: accepts items and holds them in a two-entry queue.
// Depends on psts_pkg.
module psts_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  psts_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_ready,
  output psts_pkg::cmd_t q_cmd
);
  import psts_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/psts_back.sv -----
// Back end: task tables, ordered list of cells and operation sequencer.
// Depends on psts_pkg.
module psts_back #(
  parameter int MAX_TASKS     = psts_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_BITS = psts_pkg::PRIORITY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  psts_pkg::cmd_t q_cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output psts_pkg::rsp_t rsp
);
  import psts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);
  localparam int LW = $clog2(MAX_TASKS + 1);

  logic [SW-1:0]            ord_r  [MAX_TASKS];
  status_t                  st_r   [MAX_TASKS];
  logic [PRIORITY_BITS-1:0] pri_r  [MAX_TASKS];
  logic [31:0]              wake_r [MAX_TASKS];
  logic [MAX_TASKS-1:0]     act_r;
  logic [LW-1:0]            len_r;
  logic                     cur_v_r;
  logic [SW-1:0]            cur_r;

  cmd_t    cmd_r;
  logic    busy_r;
  logic    out_v_r;
  rsp_t    out_r;
  rsp_t    out_nxt;

  logic    slot_ok;
  logic [SW-1:0] slot;
  logic [31:0] wake_sum;
  logic [MAX_TASKS-1:0] pos_lt, pos_hit, pos_rdy;
  logic [LW-1:0] ins_pos, rem_pos, pick_pos;
  logic    rem_found, pick_found;
  logic [PRIORITY_BITS-1:0] new_pri;

  assign q_ready   = !busy_r && (!out_v_r || rsp_ready);
  assign rsp_valid = out_v_r;
  assign rsp       = out_r;

  assign slot_ok  = (int'(cmd_r.task_req) < MAX_TASKS);
  assign slot     = SW'(cmd_r.task_req);
  assign wake_sum = cmd_r.now + cmd_r.delay;
  assign new_pri  = pri_r[slot];

  // per-cell compares
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      pos_lt[i]  = (LW'(i) < len_r) && (new_pri > pri_r[ord_r[i]]);
      pos_hit[i] = (LW'(i) < len_r) && (ord_r[i] == slot);
      pos_rdy[i] = (LW'(i) < len_r) && (st_r[ord_r[i]] == ST_SLEEP) &&
                   (cmd_r.now >= wake_r[ord_r[i]]);
    end
  end

  // first-cell encoders
  always_comb begin
    ins_pos = len_r;
    rem_pos = '0; rem_found = 1'b0;
    pick_pos = '0; pick_found = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!pos_lt[i] && LW'(i) < len_r) ins_pos = LW'(i);
      if (pos_hit[i]) begin
        rem_pos = LW'(i); rem_found = 1'b1;
      end
      if (pos_rdy[i]) begin
        pick_pos = LW'(i); pick_found = 1'b1;
      end
    end
  end

  // result of the held item
  always_comb begin
    out_nxt = '{task_status: ST_UNREG, picked_valid: 1'b0,
                picked_task: 4'd0, list_ok: 1'b0};
    unique case (cmd_r.op)
      OP_REGISTER: begin
        if (slot_ok) begin
          if (st_r[slot] == ST_UNREG) begin
            out_nxt.task_status = ST_DEAD;
            out_nxt.list_ok     = 1'b1;
          end else begin
            out_nxt.task_status = st_r[slot];
          end
        end
      end
      OP_ACTIVATE: begin
        if (slot_ok) begin
          if (st_r[slot] != ST_UNREG) begin
            out_nxt.task_status = ST_SLEEP;
            out_nxt.list_ok     = !act_r[slot];
          end else begin
            out_nxt.task_status = st_r[slot];
          end
        end
      end
      OP_SLEEP, OP_WAIT, OP_END: begin
        if (cur_v_r) begin
          out_nxt.list_ok = 1'b1;
          if (cmd_r.op == OP_SLEEP) out_nxt.task_status = ST_SLEEP;
          else if (cmd_r.op == OP_WAIT) out_nxt.task_status = ST_WAIT;
          else out_nxt.task_status = ST_DEAD;
        end
      end
      OP_KILL: begin
        if (slot_ok) begin
          if (st_r[slot] != ST_UNREG) begin
            out_nxt.task_status = ST_DEAD;
            out_nxt.list_ok     = rem_found;
          end else begin
            out_nxt.task_status = st_r[slot];
          end
        end
      end
      OP_PICK: begin
        if (!cur_v_r && pick_found) begin
          out_nxt.picked_valid = 1'b1;
          out_nxt.picked_task  = 4'(ord_r[pick_pos[SW-1:0]]);
          out_nxt.task_status  = ST_RUN;
        end
      end
      OP_QUERY: begin
        if (slot_ok) out_nxt.task_status = st_r[slot];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cmd_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
      act_r   <= '0;
      len_r   <= '0;
      cur_v_r <= 1'b0;
      cur_r   <= '0;
      for (int i = 0; i < MAX_TASKS; i++) st_r[i] <= ST_UNREG;
    end else begin
      if (out_v_r && rsp_ready) out_v_r <= 1'b0;
      if (q_valid && q_ready) busy_r <= 1'b1;
      if (busy_r) begin
        busy_r  <= 1'b0;
        out_v_r <= 1'b1;
        out_r   <= out_nxt;
        unique case (cmd_r.op)
          OP_REGISTER: begin
            if (slot_ok && st_r[slot] == ST_UNREG) begin
              st_r[slot]  <= ST_DEAD;
              pri_r[slot] <= PRIORITY_BITS'(cmd_r.priority_req);
            end
          end
          OP_ACTIVATE: begin
            if (slot_ok && st_r[slot] != ST_UNREG) begin
              st_r[slot]   <= ST_SLEEP;
              wake_r[slot] <= wake_sum;
              if (!act_r[slot]) begin
                if (len_r < LW'(MAX_TASKS)) begin
                  for (int i = 1; i < MAX_TASKS; i++)
                    if (LW'(i) > ins_pos) ord_r[i] <= ord_r[i-1];
                  ord_r[ins_pos[SW-1:0]] <= slot;
                  len_r       <= len_r + 1'b1;
                  act_r[slot] <= 1'b1;
                end
              end
            end
          end
          OP_SLEEP, OP_WAIT, OP_END: begin
            if (cur_v_r) begin
              cur_v_r <= 1'b0;
              unique case (cmd_r.op)
                OP_SLEEP: begin
                  wake_r[cur_r] <= wake_sum;
                  st_r[cur_r]   <= ST_SLEEP;
                end
                OP_WAIT: begin
                  st_r[cur_r] <= ST_WAIT;
                end
                default: begin
                  st_r[cur_r] <= ST_DEAD;
                end
              endcase
            end
          end
          OP_KILL: begin
            if (slot_ok && st_r[slot] != ST_UNREG) begin
              st_r[slot] <= ST_DEAD;
              if (rem_found) begin
                for (int i = 0; i < MAX_TASKS - 1; i++)
                  if (LW'(i) >= rem_pos) ord_r[i] <= ord_r[i+1];
                len_r       <= len_r - 1'b1;
                act_r[slot] <= 1'b0;
              end
            end
          end
          OP_PICK: begin
            if (!cur_v_r && pick_found) begin
              st_r[ord_r[pick_pos[SW-1:0]]] <= ST_RUN;
              cur_v_r <= 1'b1;
              cur_r   <= ord_r[pick_pos[SW-1:0]];
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_priority_sleep_task_scheduler.sv -----
// Self-checking testbench for priority_sleep_task_scheduler.
// Depends on psts_pkg and the scheduler RTL; predicts each result from a
// behavioral copy of the ordered task list and checks it at the result port.
`timescale 1ns / 100ps
module tb_priority_sleep_task_scheduler;
  import psts_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t    st;
    logic       pv;
    logic [3:0] pt;
    logic       ok;
  } sched_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [3:0]  in_task_req = '0;
  logic [7:0]  in_priority_req = '0;
  logic [31:0] in_delay = '0;
  logic [31:0] in_now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_task_status;
  logic        out_picked_valid;
  logic [3:0]  out_picked_task;
  logic        out_list_ok;

  priority_sleep_task_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_task_req(in_task_req), .in_priority_req(in_priority_req),
    .in_delay(in_delay), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_task_status(out_task_status), .out_picked_valid(out_picked_valid),
    .out_picked_task(out_picked_task), .out_list_ok(out_list_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scheduler shadow state
  logic [3:0]  run_order[NSLOT];
  int          run_len;
  status_t     slot_st[NSLOT];
  logic [7:0]  slot_prio[NSLOT];
  logic [31:0] slot_wake[NSLOT];
  logic        slot_listed[NSLOT];
  logic        cur_vld;
  logic [3:0]  cur_slot;

  sched_rsp_t  pending_rsp[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  logic [31:0] tick = 0;

  function automatic void sched_clear();
    run_len = 0;
    cur_vld = 0;
    cur_slot = 0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_st[i] = ST_UNREG;
      slot_listed[i] = 0;
      slot_prio[i] = 0;
      slot_wake[i] = 0;
      run_order[i] = 0;
    end
  endfunction

  function automatic void list_add(logic [3:0] s);
    int pos;
    pos = 0;
    if (run_len >= NSLOT) return;
    while (pos < run_len && slot_prio[s] > slot_prio[run_order[pos]]) pos++;
    for (int i = run_len; i > pos; i--) run_order[i] = run_order[i-1];
    run_order[pos] = s;
    run_len++;
    slot_listed[s] = 1;
  endfunction

  function automatic bit list_drop(logic [3:0] s);
    int pos;
    pos = 0;
    while (pos < run_len && run_order[pos] != s) pos++;
    if (pos >= run_len) return 0;
    for (int i = pos; i + 1 < run_len; i++) run_order[i] = run_order[i+1];
    run_len--;
    slot_listed[s] = 0;
    return 1;
  endfunction

  function automatic sched_rsp_t sched_apply(op_t op, logic [3:0] s, logic [7:0] pr,
                                             logic [31:0] dly, logic [31:0] nw);
    sched_rsp_t r;
    r = '{st: ST_UNREG, pv: 0, pt: 0, ok: 0};
    case (op)
      OP_REGISTER: begin
        if (slot_st[s] == ST_UNREG) begin
          slot_st[s] = ST_DEAD;
          slot_prio[s] = pr;
          r.ok = 1;
        end
      end
      OP_ACTIVATE: begin
        if (slot_st[s] != ST_UNREG) begin
          slot_st[s] = ST_SLEEP;
          slot_wake[s] = nw + dly;
          if (!slot_listed[s]) begin
            list_add(s);
            r.ok = 1;
          end
        end
      end
      OP_SLEEP, OP_WAIT, OP_END: begin
        if (cur_vld) begin
          if (op == OP_SLEEP) begin
            slot_wake[cur_slot] = nw + dly;
            slot_st[cur_slot] = ST_SLEEP;
          end else if (op == OP_WAIT) slot_st[cur_slot] = ST_WAIT;
          else slot_st[cur_slot] = ST_DEAD;
          r.st = slot_st[cur_slot];
          cur_vld = 0;
          r.ok = 1;
        end
      end
      OP_KILL: begin
        if (slot_st[s] != ST_UNREG) begin
          slot_st[s] = ST_DEAD;
          r.ok = list_drop(s);
        end
      end
      OP_PICK: begin
        if (!cur_vld) begin
          for (int i = 0; i < run_len; i++) begin
            if (slot_st[run_order[i]] == ST_SLEEP && nw >= slot_wake[run_order[i]]) begin
              slot_st[run_order[i]] = ST_RUN;
              cur_vld = 1;
              cur_slot = run_order[i];
              r.pv = 1;
              r.pt = run_order[i];
              r.st = ST_RUN;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    if (op inside {OP_REGISTER, OP_ACTIVATE, OP_KILL, OP_QUERY}) r.st = slot_st[s];
    return r;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(op_t op, logic [3:0] s, logic [7:0] pr,
                           logic [31:0] dly, logic [31:0] nw);
    int gap;
    gap = short_or_long_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_task_req <= s;
    in_priority_req <= pr;
    in_delay <= dly;
    in_now <= nw;
    do @(posedge clk); while (!in_ready);
    pending_rsp.push_back(sched_apply(op, s, pr, dly, nw));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    sched_rsp_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      idle_cycles <= 0;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result st=%0d pv=%0d pt=%0d ok=%0d", $time,
                 out_task_status, out_picked_valid, out_picked_task, out_list_ok);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (out_task_status !== exp_r.st || out_picked_valid !== exp_r.pv ||
            out_picked_task !== exp_r.pt || out_list_ok !== exp_r.ok) begin
          $display("%0t: mismatch expected st=%0d pv=%0d pt=%0d ok=%0d",
                   $time, exp_r.st, exp_r.pv, exp_r.pt, exp_r.ok,
                   " actual st=%0d pv=%0d pt=%0d ok=%0d", out_task_status,
                   out_picked_valid, out_picked_task, out_list_ok);
          errors++;
        end
      end
    end else if (rst_n && in_valid && in_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stalls
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else begin
        gap = short_or_long_gap();
        if (gap == 0) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_QUERY, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_PICK, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_SLEEP, 4'd0, 8'd0, 32'd5, 32'd0);
    send_item(OP_ACTIVATE, 4'd3, 8'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 4'd15, 8'hFF, 32'd0, 32'd0);
    send_item(OP_REGISTER, 4'd0, 8'h00, 32'd0, 32'd0);
    send_item(OP_REGISTER, 4'd7, 8'hFF, 32'd0, 32'd0);
    send_item(OP_REGISTER, 4'd7, 8'h01, 32'd0, 32'd0);
    send_item(OP_ACTIVATE, 4'd15, 8'd0, 32'hFFFF_FFFF, 32'd1);
    send_item(OP_ACTIVATE, 4'd7, 8'd0, 32'd10, 32'hFFFF_FFF0);
    send_item(OP_ACTIVATE, 4'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PICK, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_PICK, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_SLEEP, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_PICK, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_WAIT, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_PICK, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_KILL, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_END, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_ACTIVATE, 4'd0, 8'd0, 32'd0, 32'd0);
    send_item(OP_KILL, 4'd9, 8'd0, 32'd0, 32'd0);
    send_item(OP_QUERY, 4'd7, 8'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send_item(OP_QUERY, 4'(i), 8'd0, 32'd0, 32'd0);
    join
    wait_drained();
  endtask

  task automatic test_random(int n);
    op_t op;
    int r;
    logic [31:0] dly;
    logic [31:0] nw;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) op = OP_REGISTER;
      else if (r < 28) op = OP_ACTIVATE;
      else if (r < 40) op = OP_SLEEP;
      else if (r < 46) op = OP_WAIT;
      else if (r < 52) op = OP_END;
      else if (r < 60) op = OP_KILL;
      else if (r < 90) op = OP_PICK;
      else op = OP_QUERY;
      tick = tick + $urandom_range(0, 20);
      dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 30);
      nw = ($urandom_range(0, 19) == 0) ? $urandom() : tick;
      send_item(op, 4'($urandom_range(0, 15)), 8'($urandom()), dly, nw);
      if (i % 150 == 149) wait_drained();
    end
  endtask

  initial begin
    sched_clear();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(680);
    wait_drained();
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
